### design/epid_pkg.sv
// Shared types and constants of the encoder PID H-bridge drive.
package epid_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP       = 3'd0,
    REG_KI       = 3'd1,
    REG_KD       = 3'd2,
    REG_SPEED    = 3'd3,
    REG_DEADBAND = 3'd4
  } cfg_reg_t;

  localparam logic [14:0] SPEED_LIMIT_RST = 15'd32767;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  // Channel payloads.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] encoder_count;
    logic [31:0] target_position;
  } in_t;

  typedef struct packed {
    logic [14:0] drive_a;
    logic [14:0] drive_b;
    logic [15:0] control_value;
    logic [1:0]  direction;
  } out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          wdata;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture input transaction, update position and dt
    logic err;       // compute error, set up the derivative divide and the integral product
    logic div_start; // derivative divide start (the datapath sets the divider up on err)
    logic div_step;  // one divider iteration
    logic integ;     // update integral
    logic mul_sel_kp;
    logic mul_sel_kd;
    logic mul_sel_ki;
    logic mul_step;  // one partial product accumulate
    logic finish;    // clamp and form the result, commit state
  } epid_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
  } epid_sts_t;

endpackage

### design/epid_if.sv
// Valid/ready channel interface carrying a generic payload.
interface epid_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/epid_ctrl.sv
// Controller state machine sequencing the PID datapath.
module epid_ctrl
  import epid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_free,
  input  epid_sts_t sts,
  output epid_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ERR   = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_INTEG = 9'b000001000,
    S_MKP   = 9'b000010000,
    S_MKD   = 9'b000100000,
    S_MKI   = 9'b001000000,
    S_WAIT  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_INTEG;
        end
      end
      S_INTEG: begin
        cmd.integ = 1'b1;
        state_nxt = S_MKP;
      end
      S_MKP: begin
        cmd.mul_sel_kp = 1'b1;
        cmd.mul_step = 1'b1;
        if (sts.mul_done) begin
          state_nxt = S_MKD;
        end
      end
      S_MKD: begin
        cmd.mul_sel_kd = 1'b1;
        cmd.mul_step = 1'b1;
        if (sts.mul_done) begin
          state_nxt = S_MKI;
        end
      end
      S_MKI: begin
        cmd.mul_sel_ki = 1'b1;
        cmd.mul_step = 1'b1;
        if (sts.mul_done) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### design/epid_dp.sv
// PID datapath: position tracking, serial divider, shared multiplier, output.
module epid_dp
  import epid_pkg::*;
#(
  parameter int unsigned ENCODER_WIDTH  = 16,
  parameter int unsigned INTEGRAL_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  epid_cmd_t         cmd,
  output epid_sts_t         sts,
  input  logic [31:0]       now_ms,
  input  logic [15:0]       encoder_count,
  input  logic signed [31:0] target_position,
  input  logic signed [31:0] kp_gain,
  input  logic signed [31:0] ki_gain,
  input  logic signed [31:0] kd_gain,
  input  logic [14:0]       speed_limit,
  input  logic [14:0]       deadband,
  output logic [14:0]       drive_a,
  output logic [14:0]       drive_b,
  output logic signed [15:0] control_value,
  output logic [1:0]        direction
);

  localparam int unsigned IW = INTEGRAL_WIDTH;
  // Multiplicand operand wide enough for the integral and the 34-bit
  // derivative; split in 32-bit chunks, at least two.
  localparam int unsigned NCHUNK = (IW > 32) ? (IW + 31) / 32 : 2;
  localparam int unsigned MOP_W = NCHUNK * 32;
  localparam int unsigned SUM_W = IW + 36;
  localparam int unsigned CH_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  logic [ENCODER_WIDTH-1:0] last_count_r;
  logic [31:0]              position_r, pos_nxt;
  logic [31:0]              last_time_r, now_r, dt_r;
  logic signed [31:0]       prev_err_r, err_r;
  logic signed [31:0]       target_r;
  logic signed [IW-1:0]     integ_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [14:0]              drive_a_r, drive_b_r;
  logic signed [15:0]       cv_r;
  logic [1:0]               dir_r;

  // Position and elapsed time on load.
  logic [ENCODER_WIDTH-1:0] count_w;
  logic [ENCODER_WIDTH-1:0] delta;
  logic [31:0]              dt_raw;
  assign count_w = ENCODER_WIDTH'(encoder_count);
  assign delta  = count_w - last_count_r;
  assign pos_nxt = position_r + 32'(signed'(delta));
  assign dt_raw = now_ms - last_time_r;

  // Saturated error.
  logic signed [32:0] err_wide;
  logic signed [31:0] err_sat;
  assign err_wide = 33'(target_r) - 33'(signed'(position_r));
  always_comb begin
    if (err_wide > 33'sd2147483647) begin
      err_sat = 32'sh7fffffff;
    end else if (err_wide < -33'sd2147483648) begin
      err_sat = 32'sh80000000;
    end else begin
      err_sat = err_wide[31:0];
    end
  end

  // Restoring divider, magnitude 33-bit numerator by 32-bit dt.
  logic [32:0] dnum_r;   // quotient bits shift in here
  logic [32:0] drem_r;
  logic [5:0]  dcnt_r;
  logic        dneg_r;
  logic signed [32:0] dnum_s;
  logic [33:0] dtrial;
  assign dnum_s = 33'(err_sat) - 33'(prev_err_r);
  assign dtrial = {drem_r, dnum_r[32]} - {2'b0, dt_r};

  logic signed [33:0] deriv;
  assign deriv = dneg_r ? -$signed({1'b0, dnum_r}) : $signed({1'b0, dnum_r});

  // Integral update: err * dt, 32x32 multiply then saturating add.
  logic signed [64:0] edt;
  logic signed [IW+65:0] isum;
  logic signed [IW-1:0] integ_nxt;
  localparam logic signed [IW+65:0] IMAX = (IW+66)'({1'b0, {(IW-1){1'b1}}});
  localparam logic signed [IW+65:0] IMIN = -IMAX - 1;
  assign edt = err_r * $signed({1'b0, dt_r});
  assign isum = (IW+66)'(integ_r) + (IW+66)'(edt);
  always_comb begin
    if (isum > IMAX) begin
      integ_nxt = IMAX[IW-1:0];
    end else if (isum < IMIN) begin
      integ_nxt = IMIN[IW-1:0];
    end else begin
      integ_nxt = isum[IW-1:0];
    end
  end

  // Shared multiplier: gain times a 32-bit chunk of the operand per cycle.
  logic [CH_W-1:0]         mch_r;
  logic signed [MOP_W-1:0] mop;
  logic signed [31:0]      mgain;
  logic [31:0]             mchunk;
  logic                    mtop;
  logic signed [64:0]      mprod;
  always_comb begin
    mop = MOP_W'(signed'(err_r));
    mgain = kp_gain;
    if (cmd.mul_sel_kd) begin
      mop = MOP_W'(deriv);
      mgain = kd_gain;
    end else if (cmd.mul_sel_ki) begin
      mop = MOP_W'(integ_r);
      mgain = ki_gain;
    end
  end
  // The kp operand fits one chunk; the derivative and the integral take all.
  logic [CH_W-1:0] mlast;
  assign mlast = (cmd.mul_sel_ki || cmd.mul_sel_kd) ? CH_W'(NCHUNK - 1) : '0;
  assign mchunk = mop[32*mch_r +: 32];
  assign mtop = (mch_r == CH_W'(NCHUNK - 1));
  // Top chunk is signed, lower chunks unsigned.
  assign mprod = mgain * $signed({(mtop || (mlast == '0)) ? mchunk[31] : 1'b0, mchunk});
  logic signed [SUM_W-1:0] mshift;
  assign mshift = SUM_W'(mprod) <<< (32 * mch_r);

  assign sts.div_done = (dcnt_r == 6'd33);
  assign sts.mul_done = (mch_r == mlast);

  // Final clamp and drive decision.
  logic signed [SUM_W-1:0] lim, band;
  logic signed [SUM_W-1:0] ctrl;
  logic signed [SUM_W-1:0] cv_full;
  logic [15:0]             mag;
  assign lim  = SUM_W'({1'b0, speed_limit, 16'b0});
  assign band = SUM_W'({1'b0, deadband, 16'b0});
  always_comb begin
    if (sum_r > lim) begin
      ctrl = lim;
    end else if (sum_r < -lim) begin
      ctrl = -lim;
    end else begin
      ctrl = sum_r;
    end
  end
  // Truncate toward zero.
  assign cv_full = (ctrl < 0) ? -((-ctrl) >>> 16) : (ctrl >>> 16);
  assign mag = cv_full[15] ? 16'(-cv_full[15:0]) : cv_full[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      position_r   <= '0;
      last_time_r  <= '0;
      prev_err_r   <= '0;
      integ_r      <= '0;
      dir_r        <= DIR_STOP;
      drive_a_r    <= '0;
      drive_b_r    <= '0;
      cv_r         <= '0;
      mch_r        <= '0;
      dcnt_r       <= '0;
    end else begin
      if (cmd.load) begin
        last_count_r <= count_w;
        position_r   <= pos_nxt;
        now_r        <= now_ms;
        dt_r         <= (dt_raw == '0) ? 32'd1 : dt_raw;
        target_r     <= target_position;
      end
      if (cmd.err) begin
        err_r  <= err_sat;
        dneg_r <= dnum_s[32];
        dnum_r <= dnum_s[32] ? 33'(-dnum_s) : 33'(dnum_s);
        drem_r <= '0;
        dcnt_r <= '0;
        sum_r  <= '0;
        mch_r  <= '0;
      end
      if (cmd.div_step && !sts.div_done) begin
        if (!dtrial[33]) begin
          drem_r <= dtrial[32:0];
          dnum_r <= {dnum_r[31:0], 1'b1};
        end else begin
          drem_r <= {drem_r[31:0], dnum_r[32]};
          dnum_r <= {dnum_r[31:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 6'd1;
      end
      if (cmd.integ) begin
        integ_r <= integ_nxt;
      end
      if (cmd.mul_step) begin
        sum_r <= sum_r + mshift;
        mch_r <= sts.mul_done ? '0 : mch_r + CH_W'(1);
      end
      if (cmd.finish) begin
        prev_err_r  <= err_r;
        last_time_r <= now_r;
        cv_r        <= cv_full[15:0];
        if (ctrl > band) begin
          dir_r <= DIR_FWD; drive_b_r <= mag[14:0]; drive_a_r <= '0;
        end else if (ctrl < -band) begin
          dir_r <= DIR_BWD; drive_a_r <= mag[14:0]; drive_b_r <= '0;
        end else begin
          dir_r <= DIR_STOP; drive_a_r <= '0; drive_b_r <= '0;
        end
      end
    end
  end

  assign drive_a       = drive_a_r;
  assign drive_b       = drive_b_r;
  assign control_value = cv_r;
  assign direction     = dir_r;

endmodule

### design/encoder_pid_hbridge_drive.sv
// Top level of the encoder PID H-bridge drive.
//
//  channel | dir | payload
//  in_     | in  | now_ms[31:0], encoder_count[15:0], target_position[31:0]
//  out_    | out | drive_a[14:0], drive_b[14:0], control_value[15:0], direction[1:0]
//  cfg_    | in  | index[2:0], wdata[31:0]
//
// A transaction runs from acceptance to the next acceptance, with a free
// output, through load, error, the divider iterations and a done step,
// integral, the kp, kd and ki products chunk by chunk on the shared 32x32
// multiplier, wait and finish; the serial divider is its longest step.
// Reset clears gains, state and the output register; one item is in work at a
// time, and the finished result sits in the output register while the next
// transaction is accepted; a stalled output holds the next finish step.
module encoder_pid_hbridge_drive
  import epid_pkg::*;
#(
  parameter int unsigned ENCODER_WIDTH  = 16,
  parameter int unsigned INTEGRAL_WIDTH = 48
) (
  input logic clk,
  input logic rst_n,
  epid_if.sink   in_ch,
  epid_if.source out_ch,
  epid_if.sink   cfg_ch
);

  logic signed [31:0] kp_r, ki_r, kd_r;
  logic [14:0]        speed_r, band_r;
  logic               out_valid_r;
  logic               in_fire, out_free, busy;
  epid_cmd_t          cmd;
  epid_sts_t          sts;

  // Accept a new transaction only when idle.
  assign in_ch.ready  = !busy;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  // Output register may be refilled once empty or being taken.
  assign out_free     = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      speed_r <= SPEED_LIMIT_RST;
      band_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        REG_KP:       kp_r    <= cfg_ch.data.wdata;
        REG_KI:       ki_r    <= cfg_ch.data.wdata;
        REG_KD:       kd_r    <= cfg_ch.data.wdata;
        REG_SPEED:    speed_r <= cfg_ch.data.wdata[14:0];
        REG_DEADBAND: band_r  <= cfg_ch.data.wdata[14:0];
        default: ;
      endcase
    end
  end

  // Raise valid on finish, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end
  assign out_ch.valid = out_valid_r;

  epid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  epid_dp #(
    .ENCODER_WIDTH  (ENCODER_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .now_ms          (in_ch.data.now_ms),
    .encoder_count   (in_ch.data.encoder_count),
    .target_position (in_ch.data.target_position),
    .kp_gain         (kp_r),
    .ki_gain         (ki_r),
    .kd_gain         (kd_r),
    .speed_limit     (speed_r),
    .deadband        (band_r),
    .drive_a         (out_ch.data.drive_a),
    .drive_b         (out_ch.data.drive_b),
    .control_value   (out_ch.data.control_value),
    .direction       (out_ch.data.direction)
  );

endmodule

### bench/tb.sv
// Self-checking testbench for the encoder PID H-bridge drive.
`timescale 1ns / 100ps

module tb;
  import epid_pkg::*;

  // Index past the register file; the block must drop such a write.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;

  // Scoreboard: tracks controller state and the queue of pending drive outputs.
  class drive_scoreboard;
    logic signed [31:0] kp, ki, kd;
    logic [14:0] speed, band;
    logic [31:0] position, last_stamp;
    logic [15:0] last_count;
    longint prev_err, integ;
    out_t pending_drive[$];
    int errors;

    function new();
      kp = 0; ki = 0; kd = 0; speed = SPEED_LIMIT_RST; band = 0;
      position = 0; last_stamp = 0; last_count = 0; prev_err = 0; integ = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_t c);
      case (c.index)
        REG_KP:       kp = c.wdata;
        REG_KI:       ki = c.wdata;
        REG_KD:       kd = c.wdata;
        REG_SPEED:    speed = c.wdata[14:0];
        REG_DEADBAND: band = c.wdata[14:0];
        default: ;
      endcase
    endfunction

    // Advance the controller by one sample and queue the expected drive.
    function void note_input(in_t t);
      logic [15:0] d;
      logic [31:0] dt;
      longint e, dv;
      logic signed [127:0] ew, dtw, iw, sum, lim, bw, ctrl, cv, mag, imax;
      logic signed [127:0] kpw, kiw, kdw, dvw;
      out_t r;
      d = t.encoder_count - last_count;
      position = position + {{16{d[15]}}, d};
      last_count = t.encoder_count;
      dt = t.now_ms - last_stamp;
      if (dt == 0) dt = 1;
      e = longint'($signed(t.target_position)) - longint'($signed(position));
      if (e > 64'sd2147483647) e = 64'sd2147483647;
      if (e < -64'sd2147483648) e = -64'sd2147483648;
      dv = (e - prev_err) / longint'(dt);
      ew = e;
      dtw = {96'b0, dt};
      iw = integ;
      iw = iw + ew * dtw;
      imax = (128'sd1 <<< 47) - 1;
      if (iw > imax) iw = imax;
      if (iw < -imax - 1) iw = -imax - 1;
      integ = longint'(iw);
      kpw = kp; kiw = ki; kdw = kd; dvw = dv;
      sum = kpw * ew + kdw * dvw + kiw * iw;
      prev_err = e;
      last_stamp = t.now_ms;
      lim = {113'b0, speed} * 65536;
      bw = {113'b0, band} * 65536;
      ctrl = sum;
      if (ctrl > lim) ctrl = lim;
      if (ctrl < -lim) ctrl = -lim;
      cv = ctrl / 65536;
      mag = (cv < 0) ? -cv : cv;
      r = '0;
      r.control_value = cv[15:0];
      if (ctrl > bw) begin
        r.direction = DIR_FWD;
        r.drive_b = mag[14:0];
      end else if (ctrl < -bw) begin
        r.direction = DIR_BWD;
        r.drive_a = mag[14:0];
      end else begin
        r.direction = DIR_STOP;
      end
      pending_drive.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_drive.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction %h", got);
        return;
      end
      want = pending_drive.pop_front();
      if (got.drive_a !== want.drive_a || got.drive_b !== want.drive_b ||
          got.control_value !== want.control_value ||
          got.direction !== want.direction) begin
        errors++;
        if (errors <= 10)
          $display("drive a/b/cv/dir expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   want.drive_a, want.drive_b, $signed(want.control_value),
                   want.direction, got.drive_a, got.drive_b,
                   $signed(got.control_value), got.direction);
      end
    endfunction

    function int pending();
      return pending_drive.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;

  epid_if #(.payload_t(in_t))  in_ch();
  epid_if #(.payload_t(out_t)) out_ch();
  epid_if #(.payload_t(cfg_t)) cfg_ch();

  encoder_pid_hbridge_drive dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  drive_scoreboard sb = new();
  int cycles = 0;
  bit hold_req = 0;   // main flow asks the receiver for one long hold-off
  int hold_cnt = 0;
  int rx_mode = 0;
  int rx_left = 0;

  // Stimulus generator state: running time stamp and encoder counter.
  logic [31:0] gen_now = 0;
  logic [15:0] gen_cnt = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    out_ch.ready = 0;
  end

  // Watchdog: end the run with a mismatch once the cycle limit is passed.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("encoder_pid_hbridge_drive: mismatch");
      $finish;
    end
  end

  // Check every drive transaction at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Receiver backpressure: switch between always-ready, random and periodic
  // stall patterns, with a long hold-off when the main flow asks for it.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else begin
      if (hold_req) begin
        hold_cnt = 400;
        hold_req = 0;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 0;
      end else begin
        case (rx_mode)
          0: out_ch.ready <= 1;
          1: out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= (cycles % 7) < 3;
        endcase
      end
    end
  end

  // Offer one sample and hold it until the block takes it.
  task automatic send_sample(in_t t);
    @(negedge clk);
    in_ch.valid <= 1;
    in_ch.data <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(t);
  endtask

  task automatic drop_valid(int gap);
    @(negedge clk);
    in_ch.valid <= 0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_t c;
    c.index = idx;
    c.wdata = val;
    @(negedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.data <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(c);
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  // Let every expected drive arrive, then let the datapath settle.
  task automatic wait_idle();
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                           logic [14:0] lim, logic [14:0] db);
    write_reg(REG_KP, p);
    write_reg(REG_KI, i);
    write_reg(REG_KD, d);
    write_reg(REG_SPEED, {17'b0, lim});
    write_reg(REG_DEADBAND, {17'b0, db});
  endtask

  // Mostly a plausible motion trace: small time steps and encoder moves,
  // targets near the tracked position; now and then raw noise.
  function automatic in_t make_sample();
    in_t t;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      gen_now = $urandom;
      gen_cnt = 16'($urandom);
      t.target_position = $urandom;
    end else begin
      if (kind == 1) gen_now = gen_now - $urandom_range(0, 50);
      else gen_now = gen_now + $urandom_range(0, 20);
      gen_cnt = gen_cnt + 16'($signed($urandom_range(0, 400)) - 200);
      t.target_position = sb.position + 32'($signed($urandom_range(0, 2000)) - 1000);
    end
    t.now_ms = gen_now;
    t.encoder_count = gen_cnt;
    return t;
  endfunction

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        send_sample(make_sample());
        n--;
      end
      if ($urandom_range(0, 2) != 0) drop_valid($urandom_range(0, 60));
    end
    drop_valid(0);
  endtask

  task automatic directed_part();
    in_t t;
    // Same time stamp (elapsed time forced to one), then time going back.
    t = '{32'd0, 16'd0, 32'd100};             send_sample(t);
    t = '{32'd0, 16'd1, 32'd100};             send_sample(t);
    t = '{32'hFFFF_FFFF, 16'hFFFF, 32'd0};    send_sample(t);
    t = '{32'd5, 16'h8000, -32'sd5};          send_sample(t);
    t = '{32'd3, 16'h7FFF, 32'h7FFF_FFFF};    send_sample(t);
    // Error saturation at both ends of the signed range.
    t = '{32'd10, 16'h0000, 32'h8000_0000};   send_sample(t);
    t = '{32'd11, 16'hFFFF, 32'h7FFF_FFFF};   send_sample(t);
    t = '{32'd11, 16'h8001, 32'h8000_0000};   send_sample(t);
    t = '{32'h8000_0000, 16'h5555, 32'hAAAA_AAAA}; send_sample(t);
    t = '{32'h7FFF_FFFF, 16'hAAAA, 32'h5555_5555}; send_sample(t);
    t = '{32'd20, 16'h0000, 32'd0};           send_sample(t);
    t = '{32'd21, 16'h0001, 32'd2};           send_sample(t);
    drop_valid(0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Reset defaults first: all gains zero, drive stays stopped.
    random_phase(20);
    wait_idle();
    set_gains(32'h0001_0000, 32'h0000_0100, 32'h0000_8000, 15'd300, 15'd4);
    directed_part();
    wait_idle();
    // Fractional control near the deadband edge.
    set_gains(32'h0000_4000, 32'd0, 32'd0, 15'd1000, 15'd0);
    random_phase(40);
    wait_idle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    // Largest gains with full speed; hold the receiver off so the block fills.
    set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 15'h7FFF, 15'd0);
    hold_req = 1;
    random_phase(60);
    wait_idle();
    set_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 15'h7FFF, 15'h7FFF);
    random_phase(40);
    wait_idle();
    set_gains(32'h0002_0000, 32'h0000_0010, 32'h0001_0000, 15'd0, 15'd0);
    random_phase(30);
    wait_idle();
    repeat (6) begin
      set_gains($urandom_range(0, 32'h0004_0000) - 32'h0001_0000,
                $urandom_range(0, 32'h400) - 32'h100,
                $urandom_range(0, 32'h0004_0000) - 32'h0001_0000,
                15'($urandom_range(0, 2000)), 15'($urandom_range(0, 50)));
      random_phase(65);
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("encoder_pid_hbridge_drive: match");
    end else begin
      $display("encoder_pid_hbridge_drive: mismatch");
    end
    $finish;
  end

endmodule

### encoder_pid_hbridge_drive.f
design/epid_pkg.sv
design/epid_if.sv
design/epid_ctrl.sv
design/epid_dp.sv
design/encoder_pid_hbridge_drive.sv
bench/tb.sv
